>>> rtl/i2p_pkg.sv
`default_nettype none

package i2p_pkg;

   // Operator codes as held on the stack; the two top codes never reach memory
   typedef logic [2:0] code_type;

   localparam code_type CODE_ADD    = 3'd0;
   localparam code_type CODE_SUB    = 3'd1;
   localparam code_type CODE_MUL    = 3'd2;
   localparam code_type CODE_DIV    = 3'd3;
   localparam code_type CODE_POW    = 3'd4;
   localparam code_type CODE_LPAREN = 3'd5;
   localparam code_type CODE_RPAREN = 3'd6;
   localparam code_type CODE_OTHER  = 3'd7;

   typedef logic [1:0] prec_type;
   typedef logic [7:0] char_type;

   localparam char_type CHAR_ADD    = 8'h2B;
   localparam char_type CHAR_SUB    = 8'h2D;
   localparam char_type CHAR_MUL    = 8'h2A;
   localparam char_type CHAR_DIV    = 8'h2F;
   localparam char_type CHAR_POW    = 8'h5E;
   localparam char_type CHAR_LPAREN = 8'h28;
   localparam char_type CHAR_RPAREN = 8'h29;

   // Map an input byte onto its code
   function automatic code_type char_to_code(input char_type ch);
      code_type c;
      case (ch)
         CHAR_ADD:    c = CODE_ADD;
         CHAR_SUB:    c = CODE_SUB;
         CHAR_MUL:    c = CODE_MUL;
         CHAR_DIV:    c = CODE_DIV;
         CHAR_POW:    c = CODE_POW;
         CHAR_LPAREN: c = CODE_LPAREN;
         CHAR_RPAREN: c = CODE_RPAREN;
         default:     c = CODE_OTHER;
      endcase
      return c;
   endfunction

   // Byte emitted for a stacked code
   function automatic char_type code_to_char(input code_type c);
      char_type ch;
      case (c)
         CODE_ADD: ch = CHAR_ADD;
         CODE_SUB: ch = CHAR_SUB;
         CODE_MUL: ch = CHAR_MUL;
         CODE_DIV: ch = CHAR_DIV;
         CODE_POW: ch = CHAR_POW;
         default:  ch = CHAR_LPAREN;
      endcase
      return ch;
   endfunction

   // Precedence; '(' ranks lowest
   function automatic prec_type code_prec(input code_type c);
      prec_type p;
      case (c)
         CODE_ADD, CODE_SUB: p = 2'd1;
         CODE_MUL, CODE_DIV: p = 2'd2;
         CODE_POW:           p = 2'd3;
         default:            p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

>>> rtl/infix_to_postfix_converter_unit.sv
`default_nettype none

// Infix to postfix converter (shunting-yard).
// Input channel req_*: one item per character (req_mode 0, byte in req_in_char)
// or an end item (req_mode 1) that flushes the operator stack and then gives
// a bare end marker carrying the sticky error flag.
// Result channel rsp_*: zero or more postfix characters per item; the last
// result of an item has rsp_run_last set.
// Steps: '(', and ')' or an operator on an empty stack, are handled in idle and
// give no result; a pass-through character is staged and released in S_FIN. A
// pop run is accepted in idle, then pops one entry per cycle while the output
// register is free (the next read is issued with each pop, which hides the RAM
// read latency), stops on an entry that stays, the matching '(' or an empty
// stack, and closes the item in S_FIN. An end item first pops every entry.
// The item's last emitted character waits in a staging register
// until the block knows whether it ends the item.
// Reset clears the state, the stack count, the error flag and the staged and
// result valid bits; the stack RAM itself is not cleared and needs no clearing pass.
// A stalled receiver holds the result in the output register; an item is
// still taken in idle, and pops wait until the output register frees up.
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_mode,
   input  wire i2p_pkg::char_type     req_in_char,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output i2p_pkg::char_type          rsp_out_char,
   output logic                       rsp_has_char,
   output logic                       rsp_run_last,
   output logic                       rsp_expr_error
);
   import i2p_pkg::*;

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_POP, S_FIN, S_MARK} state_type;
   typedef enum logic [1:0] {K_FLUSH, K_CLOSE, K_OPER, K_CHAR} kind_type;

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              err_ff, err_in;
   logic              found_ff, found_in;
   code_type          code_ff, code_in;
   logic              pend_valid_ff, pend_valid_in;
   char_type          pend_char_ff, pend_char_in;
   logic              rsp_valid_ff, rsp_valid_in;
   char_type          rsp_char_ff, rsp_char_in;
   logic              rsp_has_ff, rsp_has_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   code_type          ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   code_type          ram_rd_data;

   logic              out_free;
   logic              stack_full;
   code_type          in_code;
   logic              pop_emit;

   i2p_ram #(
      .WIDTH ($bits(code_type)),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_char_ff;
   assign rsp_has_char   = rsp_has_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_expr_error = rsp_err_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign stack_full = (count_ff == CNT_W'(STACK_DEPTH));
   assign in_code    = char_to_code(req_in_char);
   // Top of stack leaves for the output, or stops the pop run
   assign pop_emit   = (kind_ff == K_FLUSH) ||
                       ((ram_rd_data != CODE_LPAREN) &&
                        ((kind_ff == K_CLOSE) ||
                         (code_prec(ram_rd_data) >= code_prec(code_ff))));

   // Next-state and stack access
   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      found_in      = found_ff;
      code_in       = code_ff;
      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_char_in   = rsp_char_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_err_in    = rsp_err_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[ADDR_W-1:0];
      ram_wr_data   = code_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = ADDR_W'(count_ff - CNT_W'(1));

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode) begin
                  kind_in = K_FLUSH;
                  if (count_ff != '0) begin
                     ram_rd_en = 1'b1;
                     state_in  = S_POP;
                  end else begin
                     state_in  = S_MARK;
                  end
               end else begin
                  case (in_code)
                     CODE_LPAREN: begin
                        if (stack_full) begin
                           err_in = 1'b1;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_data = CODE_LPAREN;
                           count_in    = count_ff + CNT_W'(1);
                        end
                     end
                     CODE_RPAREN: begin
                        if (count_ff != '0) begin
                           kind_in   = K_CLOSE;
                           found_in  = 1'b0;
                           ram_rd_en = 1'b1;
                           state_in  = S_POP;
                        end else begin
                           err_in = 1'b1;
                        end
                     end
                     CODE_OTHER: begin
                        kind_in       = K_CHAR;
                        pend_valid_in = 1'b1;
                        pend_char_in  = req_in_char;
                        state_in      = S_FIN;
                     end
                     default: begin
                        code_in = in_code;
                        if (count_ff != '0) begin
                           kind_in   = K_OPER;
                           ram_rd_en = 1'b1;
                           state_in  = S_POP;
                        end else begin
                           // empty stack is never full
                           ram_wr_en   = 1'b1;
                           ram_wr_data = in_code;
                           count_in    = count_ff + CNT_W'(1);
                        end
                     end
                  endcase
               end
            end
         end

         // Top of stack is on the RAM read port
         S_POP: begin
            if (out_free) begin
               if (pop_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_char_in  = pend_char_ff;
                     rsp_has_in   = 1'b1;
                     rsp_last_in  = 1'b0;
                     rsp_err_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_char_in  = code_to_char(ram_rd_data);
                  count_in      = count_ff - CNT_W'(1);
                  if (count_ff > CNT_W'(1)) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(count_ff - CNT_W'(2));
                  end else begin
                     state_in = S_FIN;
                  end
               end else begin
                  // matching '(' is dropped
                  if (kind_ff == K_CLOSE) begin
                     count_in = count_ff - CNT_W'(1);
                     found_in = 1'b1;
                  end
                  state_in = S_FIN;
               end
            end
         end

         // Release the staged result and finish the item
         S_FIN: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_char_in   = pend_char_ff;
                  rsp_has_in    = 1'b1;
                  rsp_last_in   = (kind_ff != K_FLUSH);
                  rsp_err_in    = 1'b0;
                  pend_valid_in = 1'b0;
               end
               state_in = S_IDLE;
               case (kind_ff)
                  K_FLUSH: state_in = S_MARK;
                  K_OPER: begin
                     if (stack_full) begin
                        err_in = 1'b1;
                     end else begin
                        ram_wr_en = 1'b1;
                        count_in  = count_ff + CNT_W'(1);
                     end
                  end
                  K_CLOSE: begin
                     if (!found_ff) begin
                        err_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_MARK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = '0;
               rsp_has_in   = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_err_in   = err_ff;
               err_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         err_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         err_ff        <= err_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      kind_ff      <= kind_in;
      found_ff     <= found_in;
      code_ff      <= code_in;
      pend_char_ff <= pend_char_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // Stack count never passes the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   // Staged result only exists while an item is in progress
   a_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("staged result left over in idle");

   // End marker always closes its item
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> rsp_last_ff)
      else $error("end marker without run_last");

   // Error flag only travels on the end marker
   a_err_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_has_ff) |-> !rsp_err_ff)
      else $error("error flag on a character result");

   // A pop run can only begin on a non-empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && (state_in == S_POP)) |-> (count_ff != '0))
      else $error("pop started on an empty stack");

endmodule

`default_nettype wire

>>> rtl/i2p_ram.sv
`default_nettype none

module i2p_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One write port, one registered read port; read data holds without rd_en
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire
